// File: sv/bcpm_pkg.sv
// Shared types, constants and the microprogram of the balance controller.
`default_nettype none

package bcpm_pkg;

    // Configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ZERO_ANGLE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_SPEED = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_KP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_KI     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_UPRIGHT_KP   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_UPRIGHT_KD   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STEER_GAIN   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd7;

    localparam logic signed [20:0] RST_UPRIGHT_KP  = 21'sd64000;
    localparam logic signed [16:0] RST_UPRIGHT_KD  = 17'sd256;
    localparam logic signed [16:0] RST_STEER_GAIN  = -17'sd154;
    localparam logic        [14:0] RST_DRIVE_LIMIT = 15'd7200;

    // Field and datapath widths
    localparam int ERR_W   = 18;    // left + right - target
    localparam int PZ_W    = 18;    // pitch - zero angle
    localparam int FILT_W  = 18;    // filtered speed error
    localparam int INTEG_W = 15;    // speed error integral
    localparam int ISUM_W  = FILT_W + 1;
    localparam int ABS_W   = 21;    // magnitude of 3*err + 7*filt
    localparam int DRV_W   = 16;
    localparam int A_W     = 22;    // gain side of the multiplier
    localparam int ACC_W   = 58;    // upright numerator stays below 2^55
    localparam int SPD_SUM_W   = 35; // speed_kp*filt + speed_ki*integral
    localparam int STEER_SUM_W = 34; // steer_gain*yaw_rate plus headroom

    // Divide by ten: q = (a * RECIP10) >> RECIP_SHIFT, exact for a < 2^20
    localparam logic signed [A_W-1:0] RECIP10 = 22'sd838861;
    localparam int RECIP_SHIFT = 23;

    // Microprogram
    localparam int NUM_STEPS = 15;
    localparam int PC_W      = $clog2(NUM_STEPS);
    localparam int SEL_W     = 4;
    localparam int ACC_OP_W  = 3;
    localparam int ACT_W     = 3;
    localparam int COND_W    = 2;

    localparam logic [SEL_W-1:0] A_ZERO   = 4'd0;
    localparam logic [SEL_W-1:0] A_THREE  = 4'd1;
    localparam logic [SEL_W-1:0] A_SEVEN  = 4'd2;
    localparam logic [SEL_W-1:0] A_RECIP  = 4'd3;
    localparam logic [SEL_W-1:0] A_SPD_KP = 4'd4;
    localparam logic [SEL_W-1:0] A_SPD_KI = 4'd5;
    localparam logic [SEL_W-1:0] A_UPR_KP = 4'd6;
    localparam logic [SEL_W-1:0] A_UPR_KD = 4'd7;
    localparam logic [SEL_W-1:0] A_STEER  = 4'd8;

    localparam logic [SEL_W-1:0] B_ZERO  = 4'd0;
    localparam logic [SEL_W-1:0] B_ERR   = 4'd1;
    localparam logic [SEL_W-1:0] B_FILT  = 4'd2;
    localparam logic [SEL_W-1:0] B_ABS   = 4'd3;
    localparam logic [SEL_W-1:0] B_INTEG = 4'd4;
    localparam logic [SEL_W-1:0] B_PZ    = 4'd5;
    localparam logic [SEL_W-1:0] B_OFS   = 4'd6;
    localparam logic [SEL_W-1:0] B_PRATE = 4'd7;
    localparam logic [SEL_W-1:0] B_YRATE = 4'd8;

    localparam logic [ACC_OP_W-1:0] ACC_HOLD    = 3'd0;
    localparam logic [ACC_OP_W-1:0] ACC_LOAD    = 3'd1;
    localparam logic [ACC_OP_W-1:0] ACC_ADD     = 3'd2;
    localparam logic [ACC_OP_W-1:0] ACC_LOAD_SH = 3'd3;
    localparam logic [ACC_OP_W-1:0] ACC_SUB_SH  = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SIGN  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FILT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INTEG = 3'd3;
    localparam logic [ACT_W-1:0] ACT_OFS   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_UPR   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_STR   = 3'd6;
    localparam logic [ACT_W-1:0] ACT_OUT   = 3'd7;

    localparam logic [COND_W-1:0] C_NEVER    = 2'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 2'd1;
    localparam logic [COND_W-1:0] C_NO_IN    = 2'd2;
    localparam logic [COND_W-1:0] C_OUT_BUSY = 2'd3;

    typedef struct packed {
        logic [SEL_W-1:0]    a_sel;
        logic [SEL_W-1:0]    b_sel;
        logic [ACC_OP_W-1:0] acc_op;
        logic [ACT_W-1:0]    act;
        logic [COND_W-1:0]   cond;
        logic [PC_W-1:0]     target;
    } t_uword;

    typedef struct packed {
        logic no_in;
        logic out_busy;
    } t_flags;

    function automatic t_uword f_mk(
        input logic [SEL_W-1:0]    a_sel,
        input logic [SEL_W-1:0]    b_sel,
        input logic [ACC_OP_W-1:0] acc_op,
        input logic [ACT_W-1:0]    act,
        input logic [COND_W-1:0]   cond,
        input logic [PC_W-1:0]     target
    );
        t_uword w;
        w.a_sel  = a_sel;
        w.b_sel  = b_sel;
        w.acc_op = acc_op;
        w.act    = act;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // One control word per step; a product issued in step k is summed in step k+1.
    function automatic t_uword f_uword(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:  w = f_mk(A_ZERO,   B_ZERO,  ACC_HOLD,    ACT_NONE,  C_NO_IN,    4'd0);
            4'd1:  w = f_mk(A_THREE,  B_ERR,   ACC_HOLD,    ACT_NONE,  C_NEVER,    4'd0);
            4'd2:  w = f_mk(A_SEVEN,  B_FILT,  ACC_LOAD,    ACT_NONE,  C_NEVER,    4'd0);
            4'd3:  w = f_mk(A_ZERO,   B_ZERO,  ACC_ADD,     ACT_NONE,  C_NEVER,    4'd0);
            4'd4:  w = f_mk(A_RECIP,  B_ABS,   ACC_HOLD,    ACT_SIGN,  C_NEVER,    4'd0);
            4'd5:  w = f_mk(A_ZERO,   B_ZERO,  ACC_HOLD,    ACT_FILT,  C_NEVER,    4'd0);
            4'd6:  w = f_mk(A_SPD_KP, B_FILT,  ACC_HOLD,    ACT_INTEG, C_NEVER,    4'd0);
            4'd7:  w = f_mk(A_SPD_KI, B_INTEG, ACC_LOAD,    ACT_NONE,  C_NEVER,    4'd0);
            4'd8:  w = f_mk(A_UPR_KD, B_PRATE, ACC_ADD,     ACT_NONE,  C_NEVER,    4'd0);
            4'd9:  w = f_mk(A_UPR_KP, B_PZ,    ACC_LOAD_SH, ACT_OFS,   C_NEVER,    4'd0);
            4'd10: w = f_mk(A_UPR_KP, B_OFS,   ACC_ADD,     ACT_NONE,  C_NEVER,    4'd0);
            4'd11: w = f_mk(A_STEER,  B_YRATE, ACC_SUB_SH,  ACT_NONE,  C_NEVER,    4'd0);
            4'd12: w = f_mk(A_ZERO,   B_ZERO,  ACC_LOAD,    ACT_UPR,   C_NEVER,    4'd0);
            4'd13: w = f_mk(A_ZERO,   B_ZERO,  ACC_HOLD,    ACT_STR,   C_OUT_BUSY, 4'd13);
            4'd14: w = f_mk(A_ZERO,   B_ZERO,  ACC_HOLD,    ACT_OUT,   C_ALWAYS,   4'd0);
            default: w = f_mk(A_ZERO, B_ZERO,  ACC_HOLD,    ACT_NONE,  C_ALWAYS,   4'd0);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/balance_cascaded_pid_mixer.sv
// Two-wheel balance controller: cascaded speed PI, upright PD and yaw steering mixer.
// A transaction is taken in step 0 and o_out_valid rises after the last step, which is held
//   back while the previous result still waits on i_out_ready.
// One transaction at a time: the next is taken only once the 15-step microprogram that routes
//   all nine products through one shared, registered multiplier has run to its end.
// Reset: synchronous, active low; clears the sequencer, filter and integral state and
//   output valid, and loads the default gains, angles and drive limit.
`default_nettype none

module balance_cascaded_pid_mixer #(
    parameter int INTEGRAL_LIMIT = 10000,
    parameter int FRACTION_BITS  = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bcpm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bcpm_pkg::DATA_W-1:0]   pwdata,
    output logic      [bcpm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    // sensor tick
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [15:0]            i_left_count,
    input  wire logic signed [15:0]            i_right_count,
    input  wire logic signed [16:0]            i_pitch_angle,
    input  wire logic signed [15:0]            i_pitch_rate,
    input  wire logic signed [15:0]            i_yaw_rate,
    // motor drives
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [15:0]                 o_left_drive,
    output logic signed [15:0]                 o_right_drive
);
    import bcpm_pkg::*;

    // Offset of the speed loop in whole degrees, before scaling back up.
    localparam int OFS_W = SPD_SUM_W - FRACTION_BITS;
    // Value side of the multiplier: the offset or the divide-by-ten magnitude.
    localparam int B_W   = (OFS_W > ABS_W + 1) ? OFS_W : ABS_W + 1;
    localparam int P_W   = A_W + B_W;
    localparam int UPR_W = ACC_W - 2 * FRACTION_BITS;
    localparam int STR_W = STEER_SUM_W - FRACTION_BITS;
    localparam int M_W   = UPR_W + 1;
    localparam int SH_W  = $clog2(2 * FRACTION_BITS + 1);

    localparam logic signed [ISUM_W-1:0] INT_LIM = ISUM_W'(INTEGRAL_LIMIT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [16:0] r_zero_angle;
    logic signed [15:0] r_target_speed;
    logic signed [16:0] r_speed_kp;
    logic signed [16:0] r_speed_ki;
    logic signed [20:0] r_upright_kp;
    logic signed [16:0] r_upright_kd;
    logic signed [16:0] r_steer_gain;
    logic        [14:0] r_drive_limit;

    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[ADDR_W-1:2];

    // Fields narrower than the bus take the low bits of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_angle   <= '0;
            r_target_speed <= '0;
            r_speed_kp     <= '0;
            r_speed_ki     <= '0;
            r_upright_kp   <= RST_UPRIGHT_KP;
            r_upright_kd   <= RST_UPRIGHT_KD;
            r_steer_gain   <= RST_STEER_GAIN;
            r_drive_limit  <= RST_DRIVE_LIMIT;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ZERO_ANGLE:   r_zero_angle   <= pwdata[16:0];
                REG_TARGET_SPEED: r_target_speed <= pwdata[15:0];
                REG_SPEED_KP:     r_speed_kp     <= pwdata[16:0];
                REG_SPEED_KI:     r_speed_ki     <= pwdata[16:0];
                REG_UPRIGHT_KP:   r_upright_kp   <= pwdata[20:0];
                REG_UPRIGHT_KD:   r_upright_kd   <= pwdata[16:0];
                REG_STEER_GAIN:   r_steer_gain   <= pwdata[16:0];
                REG_DRIVE_LIMIT:  r_drive_limit  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read back sign-extended; the drive limit is unsigned.
    always_comb begin
        case (w_cfg_idx)
            REG_ZERO_ANGLE:   prdata = DATA_W'(r_zero_angle);
            REG_TARGET_SPEED: prdata = DATA_W'(r_target_speed);
            REG_SPEED_KP:     prdata = DATA_W'(r_speed_kp);
            REG_SPEED_KI:     prdata = DATA_W'(r_speed_ki);
            REG_UPRIGHT_KP:   prdata = DATA_W'(r_upright_kp);
            REG_UPRIGHT_KD:   prdata = DATA_W'(r_upright_kd);
            REG_STEER_GAIN:   prdata = DATA_W'(r_steer_gain);
            REG_DRIVE_LIMIT:  prdata = DATA_W'(r_drive_limit);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: step 0 waits for a transaction, step 13 waits for the
    // output register to drain, step 14 writes the result.
    // ------------------------------------------------------------------
    t_uword w_ctl;
    t_flags w_flags;
    logic   w_in_take;

    assign w_flags.no_in    = !i_in_valid;
    assign w_flags.out_busy = o_out_valid && !i_out_ready;

    bcpm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_ctl)
    );

    assign o_in_ready = (w_ctl.cond == C_NO_IN);
    assign w_in_take  = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Capture the tick; the two differences are formed right away so the
    // multiplier never sees the unregistered sensor inputs.
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] r_err;
    logic signed [PZ_W-1:0]  r_pz;
    logic signed [15:0]      r_prate;
    logic signed [15:0]      r_yrate;

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_err   <= ERR_W'(i_left_count) + ERR_W'(i_right_count)
                       - ERR_W'(r_target_speed);
            r_pz    <= PZ_W'(i_pitch_angle) - PZ_W'(r_zero_angle);
            r_prate <= i_pitch_rate;
            r_yrate <= i_yaw_rate;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: gain side A, value side B, product registered.
    // ------------------------------------------------------------------
    logic signed [FILT_W-1:0]  r_filt;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [OFS_W-1:0]   r_ofs;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [P_W-1:0]     r_prod;
    logic signed [A_W-1:0]     w_a_op;
    logic signed [B_W-1:0]     w_b_op;
    logic signed [ABS_W-1:0]   w_acc_lo;
    logic        [ABS_W-1:0]   w_abs;

    // 3*err + 7*filt always fits 21 bits; take its magnitude for the divide.
    assign w_acc_lo = r_acc[ABS_W-1:0];
    assign w_abs    = w_acc_lo[ABS_W-1] ? -w_acc_lo : w_acc_lo;

    always_comb begin
        case (w_ctl.a_sel)
            A_THREE:  w_a_op = A_W'(3);
            A_SEVEN:  w_a_op = A_W'(7);
            A_RECIP:  w_a_op = RECIP10;
            A_SPD_KP: w_a_op = A_W'(r_speed_kp);
            A_SPD_KI: w_a_op = A_W'(r_speed_ki);
            A_UPR_KP: w_a_op = A_W'(r_upright_kp);
            A_UPR_KD: w_a_op = A_W'(r_upright_kd);
            A_STEER:  w_a_op = A_W'(r_steer_gain);
            default:  w_a_op = '0;
        endcase
    end

    always_comb begin
        case (w_ctl.b_sel)
            B_ERR:   w_b_op = B_W'(r_err);
            B_FILT:  w_b_op = B_W'(r_filt);
            B_ABS:   w_b_op = B_W'($unsigned(w_abs));
            B_INTEG: w_b_op = B_W'(r_integ);
            B_PZ:    w_b_op = B_W'(r_pz);
            B_OFS:   w_b_op = B_W'(r_ofs);
            B_PRATE: w_b_op = B_W'(r_prate);
            B_YRATE: w_b_op = B_W'(r_yrate);
            default: w_b_op = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a_op * w_b_op;
    end

    // ------------------------------------------------------------------
    // Accumulator: sums stay exact; the only scaling is a left shift by
    // the fraction bits for terms that carry an extra 2^F.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] w_prod_ext;
    logic signed [ACC_W-1:0] w_prod_sh;

    assign w_prod_ext = ACC_W'(r_prod);
    assign w_prod_sh  = w_prod_ext <<< FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        case (w_ctl.acc_op)
            ACC_LOAD:    r_acc <= w_prod_ext;
            ACC_ADD:     r_acc <= r_acc + w_prod_ext;
            ACC_LOAD_SH: r_acc <= w_prod_sh;
            ACC_SUB_SH:  r_acc <= r_acc - w_prod_sh;
            default:     r_acc <= r_acc;
        endcase
    end

    // Truncate toward zero by 2^F, or by 2^(2F) for the upright term:
    // bias negative values by the dropped mask, then shift arithmetically.
    logic        [SH_W-1:0]  w_tk;
    logic signed [ACC_W-1:0] w_bias;
    logic signed [ACC_W-1:0] w_trunc;

    assign w_tk    = (w_ctl.act == ACT_UPR) ? SH_W'(2 * FRACTION_BITS)
                                            : SH_W'(FRACTION_BITS);
    assign w_bias  = r_acc[ACC_W-1] ? ((ACC_W'(1) << w_tk) - ACC_W'(1)) : '0;
    assign w_trunc = (r_acc + w_bias) >>> w_tk;

    // ------------------------------------------------------------------
    // Loop state and intermediate terms
    // ------------------------------------------------------------------
    logic                      r_neg;
    logic        [FILT_W-1:0]  w_q;
    logic signed [ISUM_W-1:0]  w_isum;
    logic signed [ISUM_W-1:0]  w_iclamp;
    logic signed [UPR_W-1:0]   r_upr;
    logic signed [STR_W-1:0]   r_steer;

    // Quotient magnitude of the divide by ten; its top bit is always clear.
    assign w_q    = r_prod[RECIP_SHIFT +: FILT_W];
    assign w_isum = ISUM_W'(r_integ) + ISUM_W'(r_filt);

    always_comb begin
        if (w_isum > INT_LIM) begin
            w_iclamp = INT_LIM;
        end else if (w_isum < -INT_LIM) begin
            w_iclamp = -INT_LIM;
        end else begin
            w_iclamp = w_isum;
        end
    end

    // Filter and integral are the controller's memory across ticks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt  <= '0;
            r_integ <= '0;
        end else begin
            if (w_ctl.act == ACT_FILT) begin
                r_filt <= r_neg ? -w_q : w_q;
            end
            if (w_ctl.act == ACT_INTEG) begin
                r_integ <= w_iclamp[INTEG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_ctl.act)
            ACT_SIGN: r_neg   <= r_acc[ACC_W-1];
            ACT_OFS:  r_ofs   <= w_trunc[OFS_W-1:0];
            ACT_UPR:  r_upr   <= w_trunc[UPR_W-1:0];
            ACT_STR:  r_steer <= w_trunc[STR_W-1:0];
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Mixer and drive clamp
    // ------------------------------------------------------------------
    function automatic logic signed [DRV_W-1:0] f_clamp(
        input logic signed [M_W-1:0] v,
        input logic signed [M_W-1:0] lim
    );
        logic signed [M_W-1:0] c;
        if (v > lim) begin
            c = lim;
        end else if (v < -lim) begin
            c = -lim;
        end else begin
            c = v;
        end
        return c[DRV_W-1:0];
    endfunction

    logic signed [M_W-1:0] w_m1;
    logic signed [M_W-1:0] w_m2;
    logic signed [M_W-1:0] w_lim;

    assign w_m1  = M_W'(r_upr) - M_W'(r_steer);
    assign w_m2  = M_W'(r_upr) + M_W'(r_steer);
    assign w_lim = M_W'(r_drive_limit);

    // Output register: filled only by the last step, which runs only once
    // the previous result has left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_ctl.act == ACT_OUT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.act == ACT_OUT) begin
            o_left_drive  <= f_clamp(w_m1, w_lim);
            o_right_drive <= f_clamp(w_m2, w_lim);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_integ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= INTEGRAL_LIMIT) && (r_integ >= -INTEGRAL_LIMIT))
        else $error("speed integral outside its clamp");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> !o_in_ready)
        else $error("input ready while a transaction is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.act == ACT_OUT) |-> !o_out_valid)
        else $error("result written over a pending output");

    a_drive_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.act == ACT_OUT) |=>
            (o_out_valid
             && (o_left_drive  <= $signed({1'b0, $past(r_drive_limit)}))
             && (o_left_drive  >= -$signed({1'b0, $past(r_drive_limit)}))
             && (o_right_drive <= $signed({1'b0, $past(r_drive_limit)}))
             && (o_right_drive >= -$signed({1'b0, $past(r_drive_limit)}))))
        else $error("motor drive beyond the drive limit");
`endif

endmodule

`default_nettype wire

// File: sv/bcpm_seq.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
`default_nettype none

module bcpm_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bcpm_pkg::t_flags i_flags,
    output bcpm_pkg::t_uword      o_uword
);
    import bcpm_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            w_jump;

    assign o_uword = f_uword(r_pc);

    always_comb begin
        case (o_uword.cond)
            C_NEVER:    w_jump = 1'b0;
            C_ALWAYS:   w_jump = 1'b1;
            C_NO_IN:    w_jump = i_flags.no_in;
            C_OUT_BUSY: w_jump = i_flags.out_busy;
            default:    w_jump = 1'b1;
        endcase
        n_pc = w_jump ? o_uword.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the two-wheel balance controller.
module tb;
    import bcpm_pkg::*;

    // Arithmetic of the controller, kept apart from the RTL parameters on purpose
    localparam int     FRAC        = 8;
    localparam int     INTEG_LIMIT = 10000;
    localparam longint UNIT        = longint'(1) << FRAC;

    // Power-on values of the gain registers
    localparam int DFLT_UPRIGHT_KP = 64000;
    localparam int DFLT_UPRIGHT_KD = 256;
    localparam int DFLT_STEER_GAIN = -154;
    localparam int DFLT_DRIVE_LIM  = 7200;

    // A legitimate run never goes this long without a transaction: the longest
    // quiet stretch is the deliberate receiver hold-off plus one microprogram pass.
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int TICKS_PER_SET = 105;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [16:0] pitch;
        logic signed [15:0] prate;
        logic signed [15:0] yrate;
    } tick_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } drive_t;

    // One line of the directed plan: either a register write or a sensor tick,
    // optionally with the drive pair typed in by hand.
    typedef struct {
        bit                   is_reg;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [DATA_W-1:0]    reg_val;
        tick_t                tick;
        bit                   typed;
        drive_t               want;
    } plan_row_t;

    typedef enum {SET_TYPICAL, SET_TOP, SET_BOTTOM, SET_RAW} gain_set_e;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [15:0]       i_left_count;
    logic signed [15:0]       i_right_count;
    logic signed [16:0]       i_pitch_angle;
    logic signed [15:0]       i_pitch_rate;
    logic signed [15:0]       i_yaw_rate;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [15:0]       o_left_drive;
    logic signed [15:0]       o_right_drive;

    // Shadow copy of the gain registers
    logic signed [16:0]       cfg_zero_angle;
    logic signed [15:0]       cfg_target_speed;
    logic signed [16:0]       cfg_speed_kp;
    logic signed [16:0]       cfg_speed_ki;
    logic signed [20:0]       cfg_upright_kp;
    logic signed [16:0]       cfg_upright_kd;
    logic signed [16:0]       cfg_steer_gain;
    logic        [14:0]       cfg_drive_limit;

    // Speed loop state, held exactly
    longint                   filt_err;
    longint                   err_integ;

    drive_t                   drive_q[$];
    plan_row_t                plan[$];

    int                       tx_idle_pct;
    int                       rx_idle_pct;
    logic                     hold_pending;
    int                       quiet_cycles;
    int                       mismatches;
    int                       ticks_sent;
    int                       drives_checked;
    int                       settings_loaded;

    balance_cascaded_pid_mixer #(
        .INTEGRAL_LIMIT (INTEG_LIMIT),
        .FRACTION_BITS  (FRAC)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_count   (i_left_count),
        .i_right_count  (i_right_count),
        .i_pitch_angle  (i_pitch_angle),
        .i_pitch_rate   (i_pitch_rate),
        .i_yaw_rate     (i_yaw_rate),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_drive   (o_left_drive),
        .o_right_drive  (o_right_drive)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the speed loop by one tick and work out both motor drives.
    // Every intermediate is exact; truncation toward zero happens only at the
    // four divisions, the same way signed integer division behaves here.
    function automatic drive_t balance_drives(input tick_t t);
        longint err;
        longint offset;
        longint setpoint;
        longint upright;
        longint steer;
        longint lim;
        drive_t d;
        err       = longint'(t.left) + longint'(t.right) - longint'(cfg_target_speed);
        filt_err  = (3 * err + 7 * filt_err) / 10;
        err_integ = clip(err_integ + filt_err, -INTEG_LIMIT, INTEG_LIMIT);
        offset    = (longint'(cfg_speed_kp) * filt_err
                     + longint'(cfg_speed_ki) * err_integ) / UNIT;
        // Offset is whole degrees; scale it back into the angle format
        setpoint  = longint'(cfg_zero_angle) + offset * UNIT;
        upright   = (longint'(cfg_upright_kp) * (longint'(t.pitch) - setpoint)
                     + longint'(cfg_upright_kd) * longint'(t.prate) * UNIT) / (UNIT * UNIT);
        steer     = (longint'(cfg_steer_gain) * longint'(t.yrate)) / UNIT;
        lim       = longint'(cfg_drive_limit);
        d.left    = 16'(clip(upright - steer, -lim, lim));
        d.right   = 16'(clip(upright + steer, -lim, lim));
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Write one register through the APB port (setup, then access) and mirror it.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Leave the bus idle before the next transfer
        @(posedge i_clk);
        // Keep only the register's own width, as the hardware does
        case (idx)
            REG_ZERO_ANGLE:   cfg_zero_angle   = val[16:0];
            REG_TARGET_SPEED: cfg_target_speed = val[15:0];
            REG_SPEED_KP:     cfg_speed_kp     = val[16:0];
            REG_SPEED_KI:     cfg_speed_ki     = val[16:0];
            REG_UPRIGHT_KP:   cfg_upright_kp   = val[20:0];
            REG_UPRIGHT_KD:   cfg_upright_kd   = val[16:0];
            REG_STEER_GAIN:   cfg_steer_gain   = val[16:0];
            REG_DRIVE_LIMIT:  cfg_drive_limit  = val[14:0];
            default: ;
        endcase
    endtask

    // Drop valid and hold until every drive pair owed has come back.
    // Each tick yields exactly one pair, so an empty queue means the block is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
    endtask

    // Offer one tick, idling first at the current sender rate, and hold it until
    // accepted. The expectation is either the typed-in pair or the predicted one;
    // the predictor runs either way so the speed loop state keeps step.
    task automatic offer(input tick_t t, input bit typed, input drive_t typed_want);
        int     gap;
        drive_t pred;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_left_count  <= t.left;
        i_right_count <= t.right;
        i_pitch_angle <= t.pitch;
        i_pitch_rate  <= t.prate;
        i_yaw_rate    <= t.yrate;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = balance_drives(t);
        drive_q.push_back(typed ? typed_want : pred);
        ticks_sent++;
    endtask

    function automatic tick_t mk_tick(input int l, input int r, input int p,
                                      input int pr, input int y);
        tick_t t;
        t.left  = 16'(l);
        t.right = 16'(r);
        t.pitch = 17'(p);
        t.prate = 16'(pr);
        t.yrate = 16'(y);
        return t;
    endfunction

    function automatic void plan_tick(input tick_t t, input bit typed,
                                      input int want_l, input int want_r);
        plan_row_t row;
        row.is_reg     = 1'b0;
        row.reg_idx    = '0;
        row.reg_val    = '0;
        row.tick       = t;
        row.typed      = typed;
        row.want.left  = 16'(want_l);
        row.want.right = 16'(want_r);
        plan.push_back(row);
    endfunction

    function automatic void plan_reg(input logic [REG_IDX_W-1:0] idx, input int val);
        plan_row_t row;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = 32'(val);
        row.tick    = mk_tick(0, 0, 0, 0, 0);
        row.typed   = 1'b0;
        row.want.left  = '0;
        row.want.right = '0;
        plan.push_back(row);
    endfunction

    // Mostly a plausible robot (wheel counts drifting around a common speed,
    // pitch within +-180 degrees, modest gyro rates); one tick in four is raw
    // noise over the full width of every field, out-of-range pitch included.
    function automatic tick_t random_tick(input int drift);
        tick_t t;
        if ($urandom_range(3) == 0) begin
            t.left  = 16'($urandom());
            t.right = 16'($urandom());
            t.pitch = 17'($urandom());
            t.prate = 16'($urandom());
            t.yrate = 16'($urandom());
        end else begin
            t.left  = 16'(drift + int'($urandom_range(64)) - 32);
            t.right = 16'(drift + int'($urandom_range(64)) - 32);
            t.pitch = 17'(int'($urandom_range(92160)) - 46080);
            t.prate = 16'(int'($urandom_range(4000)) - 2000);
            t.yrate = 16'(int'($urandom_range(4000)) - 2000);
        end
        return t;
    endfunction

    // Load all eight registers from one of the gain sets. The raw set writes
    // whole random words so that the upper bits get dropped by the register widths.
    task automatic load_gains(input gain_set_e s);
        int za, ts, skp, ski, ukp, ukd, sg, dl;
        case (s)
            SET_TYPICAL: begin
                za  = int'($urandom_range(4096)) - 2048;
                ts  = int'($urandom_range(400)) - 200;
                skp = int'($urandom_range(4096)) - 2048;
                ski = int'($urandom_range(512)) - 256;
                ukp = int'($urandom_range(256000)) - 128000;
                ukd = int'($urandom_range(2048)) - 1024;
                sg  = int'($urandom_range(1024)) - 512;
                dl  = int'($urandom_range(31767)) + 1000;
            end
            SET_TOP: begin
                za  = 46080;
                ts  = 32767;
                skp = 65535;
                ski = 65535;
                ukp = 1048575;
                ukd = 65535;
                sg  = 65535;
                dl  = 32767;
            end
            SET_BOTTOM: begin
                za  = -46080;
                ts  = -32768;
                skp = -65536;
                ski = -65536;
                ukp = -1048576;
                ukd = -65536;
                sg  = -65536;
                dl  = 16384;
            end
            default: begin
                za  = $urandom();
                ts  = $urandom();
                skp = $urandom();
                ski = $urandom();
                ukp = $urandom();
                ukd = $urandom();
                sg  = $urandom();
                dl  = $urandom();
            end
        endcase
        write_reg(REG_ZERO_ANGLE,   32'(za));
        write_reg(REG_TARGET_SPEED, 32'(ts));
        write_reg(REG_SPEED_KP,     32'(skp));
        write_reg(REG_SPEED_KI,     32'(ski));
        write_reg(REG_UPRIGHT_KP,   32'(ukp));
        write_reg(REG_UPRIGHT_KD,   32'(ukd));
        write_reg(REG_STEER_GAIN,   32'(sg));
        write_reg(REG_DRIVE_LIMIT,  32'(dl));
        settings_loaded++;
    endtask

    // Drain, load a gain set, switch the idling mix and stream random ticks.
    task automatic run_phase(input gain_set_e s, input int tx_pct, input int rx_pct);
        int     drift;
        int     k;
        drive_t no_want;
        no_want.left  = '0;
        no_want.right = '0;
        settle();
        load_gains(s);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        drift = int'($urandom_range(400)) - 200;
        for (k = 0; k < TICKS_PER_SET; k++)
            offer(random_tick(drift), 1'b0, no_want);
    endtask

    // Receiver: random back-pressure at the current rate, or one long hold-off
    // on request, counted here so the sender keeps pushing into a full block.
    initial begin : rx_side
        int n;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending <= 1'b0;
                i_out_ready  <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare every accepted drive pair with the oldest one owed.
    always @(posedge i_clk) begin : drive_check
        drive_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            drives_checked++;
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("drive pair %0d/%0d with nothing owed",
                                          o_left_drive, o_right_drive));
            end else begin
                want = drive_q.pop_front();
                if (o_left_drive !== want.left)
                    report_mismatch($sformatf("left drive %0d, expected %0d",
                                              o_left_drive, want.left));
                if (o_right_drive !== want.right)
                    report_mismatch($sformatf("right drive %0d, expected %0d",
                                              o_right_drive, want.right));
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d cycles without a transaction, %0d pairs owed",
                     quiet_cycles, drive_q.size());
            $display("FAIL balance_cascaded_pid_mixer");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        plan_row_t row;
        drive_t    no_want;
        int        k;

        // Drive every input to a known value from time zero
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_left_count  <= '0;
        i_right_count <= '0;
        i_pitch_angle <= '0;
        i_pitch_rate  <= '0;
        i_yaw_rate    <= '0;
        hold_pending  <= 1'b0;
        quiet_cycles  = 0;
        mismatches    = 0;
        ticks_sent    = 0;
        drives_checked  = 0;
        settings_loaded = 0;
        tx_idle_pct   = 26;
        rx_idle_pct   = 67;
        no_want.left  = '0;
        no_want.right = '0;

        // Mirror the power-on state
        cfg_zero_angle   = '0;
        cfg_target_speed = '0;
        cfg_speed_kp     = '0;
        cfg_speed_ki     = '0;
        cfg_upright_kp   = 21'(DFLT_UPRIGHT_KP);
        cfg_upright_kd   = 17'(DFLT_UPRIGHT_KD);
        cfg_steer_gain   = 17'(DFLT_STEER_GAIN);
        cfg_drive_limit  = 15'(DFLT_DRIVE_LIM);
        filt_err         = 0;
        err_integ        = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan. With power-on gains the speed loop has no effect on the
        // drives (both speed gains are zero), so the first rows can be read off
        // by hand: upright gain 250, derivative gain 1, steering -154/256, limit 7200.
        plan_tick(mk_tick(0, 0, 0, 0, 0),               1'b1, 0, 0);
        plan_tick(mk_tick(0, 0, 46080, 0, 0),           1'b1, 7200, 7200);
        plan_tick(mk_tick(0, 0, -46080, 0, 0),          1'b1, -7200, -7200);
        // Pitch beyond +-180 degrees is still taken at face value
        plan_tick(mk_tick(0, 0, 65535, 0, 0),           1'b1, 7200, 7200);
        plan_tick(mk_tick(0, 0, -65536, 0, 0),          1'b1, -7200, -7200);
        plan_tick(mk_tick(0, 0, 256, 0, 0),             1'b1, 250, 250);
        plan_tick(mk_tick(0, 0, 0, 32767, 0),           1'b1, 7200, 7200);
        plan_tick(mk_tick(0, 0, 0, -32768, 0),          1'b1, -7200, -7200);
        plan_tick(mk_tick(0, 0, 0, 0, 32767),           1'b1, 7200, -7200);
        plan_tick(mk_tick(0, 0, 0, 0, -32768),          1'b1, -7200, 7200);
        // Wheel count extremes load the filter and saturate the integral
        plan_tick(mk_tick(32767, 32767, 0, 0, 0),       1'b1, 0, 0);
        plan_tick(mk_tick(-32768, -32768, 0, 0, 0),     1'b1, 0, 0);
        // Close the speed loop and let the predictor take over
        plan_reg(REG_SPEED_KP,     256);
        plan_reg(REG_SPEED_KI,     64);
        plan_reg(REG_TARGET_SPEED, -50);
        plan_reg(REG_ZERO_ANGLE,   512);
        plan_tick(mk_tick(20, 25, 300, -100, 40),                 1'b0, 0, 0);
        plan_tick(mk_tick(-32768, 32767, 46080, 32767, -32768),   1'b0, 0, 0);
        plan_tick(mk_tick(5, -5, -46080, -32768, 32767),          1'b0, 0, 0);
        // Zero drive limit forces both drives to zero whatever comes in
        plan_reg(REG_DRIVE_LIMIT, 0);
        plan_tick(mk_tick(32767, 32767, 46080, 32767, 32767),     1'b1, 0, 0);
        plan_reg(REG_DRIVE_LIMIT, 32767);
        plan_reg(REG_UPRIGHT_KP,  1048575);
        plan_reg(REG_UPRIGHT_KD,  65535);
        plan_reg(REG_STEER_GAIN,  -65536);
        plan_tick(mk_tick(100, 100, 46080, 32767, 32767),         1'b0, 0, 0);
        plan_tick(mk_tick(-100, -100, -65536, -32768, -32768),    1'b0, 0, 0);

        for (k = 0; k < plan.size(); k++) begin
            row = plan[k];
            if (row.is_reg) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                offer(row.tick, row.typed, row.want);
            end
        end

        // Random part: sender-light/receiver-heavy idling, then the reverse,
        // then none at all across the remaining gain sets.
        run_phase(SET_TYPICAL, 26, 67);
        run_phase(SET_TOP,     67, 26);
        run_phase(SET_BOTTOM,   0,  0);

        // Hold off the receiver for a long stretch while ticks keep coming,
        // so the result stays parked and the block backs up onto its input.
        hold_pending <= 1'b1;
        for (k = 0; k < 12; k++)
            offer(random_tick(0), 1'b0, no_want);

        run_phase(SET_RAW, 0, 0);

        // Wind down: drain, then leave room for any stray result to show up
        settle();
        repeat (20) @(posedge i_clk);

        $display("covered %0d sensor ticks under %0d gain sets plus the directed plan",
                 ticks_sent, settings_loaded);
        $display("checked %0d drive pairs, %0d mismatches", drives_checked, mismatches);
        if (mismatches == 0 && drive_q.size() == 0)
            $display("PASS balance_cascaded_pid_mixer");
        else
            $display("FAIL balance_cascaded_pid_mixer");
        $finish;
    end
endmodule
